// ===== design/elf_rel_pkg.sv =====
`timescale 1ns / 1ps

package elf_rel_pkg;

    // default symbol table depth and widest table address it may need
    localparam int SYMBOL_DEPTH_DEF = 1024;
    localparam int ADDR_W_MAX       = 16;

    // entries between front and back end
    localparam int QUEUE_DEPTH = 2;

    // size of the patched word in bytes
    localparam int PATCH_BYTES = 4;

    // handled relocation types
    localparam logic [7:0] RELOC_ABS32     = 8'd2;
    localparam logic [7:0] RELOC_REL32     = 8'd3;
    localparam logic [7:0] RELOC_GLOB_DAT  = 8'd21;
    localparam logic [7:0] RELOC_JUMP_SLOT = 8'd22;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_BASE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_SPAN   = 2'd1;
    localparam logic [1:0] REG_SYMBOL_COUNT = 2'd2;

    // input commands
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_RELOC = 1'b1;

    typedef enum logic [2:0] {
        ST_APPLIED      = 3'd0,
        ST_BAD_TYPE     = 3'd1,
        ST_BAD_SYMBOL   = 3'd2,
        ST_OUT_OF_IMAGE = 3'd3,
        ST_ZERO_VALUE   = 3'd4,
        ST_STORED       = 3'd5
    } status_t;

    // what the back end has to do with a queued item
    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_LOOKUP,
        KIND_REPORT
    } kind_t;

    // classified item passed from front to back end
    typedef struct packed {
        kind_t                   kind;
        status_t                 status;
        logic [31:0]             word;      // stored value, or patch offset
        logic [ADDR_W_MAX-1:0]   addr;      // symbol table slot
        logic                    rel32;
        logic                    write_ok;  // store slot lies inside the table
        logic                    done;
    } queue_entry_t;

    typedef enum logic {
        BK_IDLE,
        BK_WAIT
    } back_state_t;

endpackage

// ===== design/elf_rel_ram.sv =====
`timescale 1ns / 1ps

module elf_rel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/elf_rel_front.sv =====
`timescale 1ns / 1ps

module elf_rel_front #(
    parameter int SYMBOL_DEPTH = elf_rel_pkg::SYMBOL_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_command,
    input  logic [9:0]                in_symbol_index,
    input  logic [31:0]               in_symbol_value,
    input  logic                      in_symbol_defined,
    input  logic [31:0]               in_import_address,
    input  logic [31:0]               in_reloc_offset,
    input  logic [31:0]               in_reloc_info,
    input  logic                      in_end_of_table,
    output logic                      push_valid,
    input  logic                      push_ready,
    output elf_rel_pkg::queue_entry_t push_entry
);

    import elf_rel_pkg::*;

    localparam logic [31:0] DEPTH_W = 32'(SYMBOL_DEPTH);

    logic [31:0]  image_base_reg;
    logic [31:0]  image_span_reg;
    logic [10:0]  symbol_count_reg;

    logic         valid_reg;
    queue_entry_t entry_reg;
    queue_entry_t entry_next;

    logic [7:0]   rtype;
    logic [23:0]  sym;
    logic         type_ok;
    logic         sym_ok;
    logic         window_ok;
    logic [32:0]  target_end;
    logic [32:0]  window_end;
    logic [31:0]  value_sel;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_base_reg   <= '0;
            image_span_reg   <= '0;
            symbol_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_BASE:   image_base_reg   <= cfg_data;
                REG_IMAGE_SPAN:   image_span_reg   <= cfg_data;
                REG_SYMBOL_COUNT: symbol_count_reg <= cfg_data[10:0];
                default:          ;
            endcase
        end
    end

    // field split and checks of a relocation
    assign rtype      = in_reloc_info[7:0];
    assign sym        = in_reloc_info[31:8];
    assign type_ok    = (rtype == RELOC_ABS32) || (rtype == RELOC_REL32) ||
                        (rtype == RELOC_GLOB_DAT) || (rtype == RELOC_JUMP_SLOT);
    assign sym_ok     = (sym != '0) && ({8'd0, sym} < {21'd0, symbol_count_reg}) &&
                        ({8'd0, sym} < DEPTH_W);
    assign target_end = {1'b0, in_reloc_offset} + 33'(PATCH_BYTES);
    assign window_end = {1'b0, image_base_reg} + {1'b0, image_span_reg};
    assign window_ok  = (in_reloc_offset >= image_base_reg) && (target_end <= window_end);

    // the stored word is already the value a relocation will pick
    assign value_sel  = in_symbol_defined ? in_symbol_value : in_import_address;

    // classify the incoming item
    always_comb
    begin
        entry_next          = '0;
        entry_next.done     = in_end_of_table;
        entry_next.rel32    = (rtype == RELOC_REL32);
        entry_next.write_ok = ({22'd0, in_symbol_index} < DEPTH_W);
        if (in_command == CMD_STORE)
        begin
            entry_next.kind   = KIND_STORE;
            entry_next.status = ST_STORED;
            entry_next.word   = value_sel;
            entry_next.addr   = ADDR_W_MAX'(in_symbol_index);
        end
        else
        begin
            entry_next.word = in_reloc_offset;
            entry_next.addr = sym[ADDR_W_MAX-1:0];
            if (!type_ok)
            begin
                entry_next.kind   = KIND_REPORT;
                entry_next.status = ST_BAD_TYPE;
            end
            else if (!sym_ok)
            begin
                entry_next.kind   = KIND_REPORT;
                entry_next.status = ST_BAD_SYMBOL;
            end
            else if (!window_ok)
            begin
                entry_next.kind   = KIND_REPORT;
                entry_next.status = ST_OUT_OF_IMAGE;
            end
            else
            begin
                entry_next.kind   = KIND_LOOKUP;
                entry_next.status = ST_APPLIED;
            end
        end
    end

    assign in_ready = !valid_reg || push_ready;

    // input stage holding one classified item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            entry_reg <= entry_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule

// ===== design/elf_rel_queue.sv =====
`timescale 1ns / 1ps

module elf_rel_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push_valid,
    output logic                      push_ready,
    input  elf_rel_pkg::queue_entry_t push_entry,
    output logic                      head_valid,
    input  logic                      pop,
    output elf_rel_pkg::queue_entry_t head_entry
);

    import elf_rel_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    queue_entry_t     mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/elf_rel_back.sv =====
`timescale 1ns / 1ps

module elf_rel_back #(
    parameter int SYMBOL_DEPTH = elf_rel_pkg::SYMBOL_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    output logic                      pop,
    input  elf_rel_pkg::queue_entry_t head_entry,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [63:0]               out_data,
    output logic [3:0]                out_user,
    output logic                      out_last
);

    import elf_rel_pkg::*;

    localparam int ADDR_W = $clog2(SYMBOL_DEPTH);

    back_state_t  state_reg;
    back_state_t  state_next;
    queue_entry_t lookup_reg;

    logic         out_valid_reg;
    logic [63:0]  out_data_reg;
    logic [3:0]   out_user_reg;
    logic         out_last_reg;
    logic         out_load;
    logic [63:0]  out_data_next;
    logic [3:0]   out_user_next;
    logic         out_last_next;

    logic         out_free;
    logic         ram_wr_en;
    logic         ram_rd_en;
    logic [31:0]  ram_rd_data;
    logic [31:0]  rel_data;

    assign out_free  = !out_valid_reg || out_ready;
    assign ram_wr_en = pop && (head_entry.kind == KIND_STORE) && head_entry.write_ok;
    assign ram_rd_en = pop && (head_entry.kind == KIND_LOOKUP);
    assign rel_data  = ram_rd_data - lookup_reg.word;

    elf_rel_ram #(
        .WIDTH (32),
        .DEPTH (SYMBOL_DEPTH)
    ) u_symtab (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (head_entry.addr[ADDR_W-1:0]),
        .wr_data (head_entry.word),
        .rd_en   (ram_rd_en),
        .rd_addr (head_entry.addr[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, queue pop and result word
    always_comb
    begin
        state_next    = state_reg;
        pop           = 1'b0;
        out_load      = 1'b0;
        out_data_next = '0;
        out_user_next = '0;
        out_last_next = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    pop = 1'b1;
                    if (head_entry.kind == KIND_LOOKUP)
                    begin
                        state_next = BK_WAIT;
                    end
                    else
                    begin
                        out_load      = 1'b1;
                        out_user_next = {head_entry.status, 1'b0};
                        out_last_next = head_entry.done;
                    end
                end
            end
            BK_WAIT:
            begin
                state_next    = BK_IDLE;
                out_load      = 1'b1;
                out_last_next = lookup_reg.done;
                if (ram_rd_data == '0)
                begin
                    out_user_next = {ST_ZERO_VALUE, 1'b0};
                end
                else
                begin
                    out_user_next = {ST_APPLIED, 1'b1};
                    out_data_next = {lookup_reg.rel32 ? rel_data : ram_rd_data,
                                     lookup_reg.word};
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // item waiting for its table read
    always_ff @(posedge clk)
    begin
        if (ram_rd_en)
        begin
            lookup_reg <= head_entry;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

    // the wait state always follows the pop of a lookup
    a_wait_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_WAIT |-> $past(pop && head_entry.kind == KIND_LOOKUP))
        else $error("back end waits without a lookup");

    // a result is never loaded over one that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");

    // no pop while a table read is outstanding
    a_no_pop_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_WAIT |-> !pop)
        else $error("queue popped during table read");

    // a patch write is flagged only with the applied status
    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_user_reg[0] |-> out_user_reg[3:1] == ST_APPLIED)
        else $error("patch write with wrong status");

endmodule

// ===== design/elf_relocation_engine.sv =====
`timescale 1ns / 1ps

// Applies ELF32 ARM dynamic relocations (ABS32, REL32, GLOB_DAT, JUMP_SLOT)
// against an on-chip symbol table of SYMBOL_DEPTH entries. Items enter on the
// s_axis side: tuser 0 stores a symbol entry, tuser 1 applies one relocation;
// each item gives exactly one result on the m_axis side, in order, with a patch
// word flagged in tuser bit 0 and a status code in tuser bits 3..1. The front
// end checks type, symbol and image window combinationally and queues the item;
// the back end owns the symbol table and makes one access to it per cycle, so
// stores and rejected relocations leave it at one item per cycle when
// m_axis_tready stays high; a relocation that reads the table occupies the back
// end for a table read and then for its result, and the back end takes no new
// item until that result is loaded. The table needs no clearing after reset; a
// relocation naming a slot never stored returns an undefined value.
// Configuration writes must be made only while the block is idle.
module elf_relocation_engine #(
    parameter int SYMBOL_DEPTH = elf_rel_pkg::SYMBOL_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration: 0 image base, 1 image size, 2 symbol count
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // symbol_index[9:0], symbol_value[41:10], symbol_defined[42],
    // import_address[74:43], reloc_offset[106:75], reloc_info[138:107]
    input  logic [143:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // command
    input  logic         s_axis_tlast,   // end_of_table
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // write_address[31:0], write_data[63:32]
    output logic [3:0]   m_axis_tuser,   // write_valid[0], status[3:1]
    output logic         m_axis_tlast    // table_done
);

    import elf_rel_pkg::*;

    logic         push_valid;
    logic         push_ready;
    queue_entry_t push_entry;
    logic         head_valid;
    logic         pop;
    queue_entry_t head_entry;

    elf_rel_front #(
        .SYMBOL_DEPTH (SYMBOL_DEPTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .in_command        (s_axis_tuser),
        .in_symbol_index   (s_axis_tdata[9:0]),
        .in_symbol_value   (s_axis_tdata[41:10]),
        .in_symbol_defined (s_axis_tdata[42]),
        .in_import_address (s_axis_tdata[74:43]),
        .in_reloc_offset   (s_axis_tdata[106:75]),
        .in_reloc_info     (s_axis_tdata[138:107]),
        .in_end_of_table   (s_axis_tlast),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_entry        (push_entry)
    );

    elf_rel_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .head_entry (head_entry)
    );

    elf_rel_back #(
        .SYMBOL_DEPTH (SYMBOL_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .pop        (pop),
        .head_entry (head_entry),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule
